>>> rtl/hdt_pkg.sv
package hdt_pkg;

    localparam int ENERGY_W  = 24;
    localparam int HIT_E_W   = 16;
    localparam int MULT_W    = 6;
    localparam logic [MULT_W-1:0] MULT_MAX = '1;

    // action codes
    localparam logic [1:0] ACT_BEAM = 2'd0;
    localparam logic [1:0] ACT_TILE = 2'd1;
    localparam logic [1:0] ACT_END  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_BEAM_LO    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BEAM_HI    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BEAM_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_EN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_EN  = 3'd5;

    // beam mapping, positions in 1/16 mm
    localparam int X_OFFSET_Q4  = 160;  // -10 mm edge shift
    localparam int SEG_PITCH_Q4 = 224;  // 14 mm pitch = 7 * 32
    localparam int PITCH_SHIFT  = 5;
    localparam int DIV7_MUL     = 2341; // ceil(2^14 / 7), exact for values below 448
    localparam int DIV7_SHIFT   = 14;

    // first tile of the veto window (tiles 16 to 21)
    localparam int VETO_BASE_TILE = 16;

    typedef struct packed {
        logic [3:0]          beam_lo;
        logic [3:0]          beam_hi;
        logic [ENERGY_W-1:0] beam_thr;
        logic [ENERGY_W-1:0] tile_thr;
        logic                origin_en;
        logic                target_en;
    } cfg_t;

    typedef struct packed {
        logic [1:0]          action;
        logic signed [16:0]  hit_position_x;
        logic [5:0]          tile_number;
        logic [HIT_E_W-1:0]  hit_energy_kev;
        logic [31:0]         origin_tag;
        logic signed [31:0]  particle_code;
        logic                target_touched;
    } item_t;

    typedef struct packed {
        logic              event_used;
        logic              beam_present;
        logic              trigger_fired;
        logic              veto_tight;
        logic              veto_fit;
        logic              veto_wide;
        logic              veto_ultra;
        logic [MULT_W-1:0] tile_multiplicity;
    } res_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic scan_rd;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic [1:0] act;
    } status_t;

endpackage

>>> rtl/hdt_item_if.sv
interface hdt_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [16:0] hit_position_x;
    logic [5:0]         tile_number;
    logic [15:0]        hit_energy_kev;
    logic [31:0]        origin_tag;
    logic signed [31:0] particle_code;
    logic               target_touched;

    modport source (
        output valid, action, hit_position_x, tile_number, hit_energy_kev,
               origin_tag, particle_code, target_touched,
        input  ready
    );
    modport sink (
        input  valid, action, hit_position_x, tile_number, hit_energy_kev,
               origin_tag, particle_code, target_touched,
        output ready
    );
endinterface

>>> rtl/hdt_result_if.sv
interface hdt_result_if;
    logic       valid;
    logic       ready;
    logic       event_used;
    logic       beam_present;
    logic       trigger_fired;
    logic       veto_tight;
    logic       veto_fit;
    logic       veto_wide;
    logic       veto_ultra;
    logic [5:0] tile_multiplicity;

    modport source (
        output valid, event_used, beam_present, trigger_fired, veto_tight,
               veto_fit, veto_wide, veto_ultra, tile_multiplicity,
        input  ready
    );
    modport sink (
        input  valid, event_used, beam_present, trigger_fired, veto_tight,
               veto_fit, veto_wide, veto_ultra, tile_multiplicity,
        output ready
    );
endinterface

>>> rtl/hdt_cfg_if.sv
interface hdt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/hodoscope_trigger_veto_core.sv
// Event trigger for a beam hodoscope and a tile barrel. Beam and tile hits
// each take an accumulator memory read, then a saturating write-back, and a
// new hit is accepted only once the last one is written back. An end-of-event
// request sweeps both accumulator memories over max(BEAM_SEGMENTS, TILE_COUNT)
// addresses, one address per cycle, through a registered compare stage, then
// the result register is loaded; a further wait occurs only while the previous
// result has not been taken. Accumulators are cleared at once at result load
// via per-entry hit flags, so no clearing pass is needed after reset or per
// event. The config port is always ready; write it only while idle.
module hodoscope_trigger_veto_core #(
    parameter int BEAM_SEGMENTS = 15,
    parameter int TILE_COUNT    = 34
) (
    input  logic        clk,
    input  logic        rst_n,
    hdt_item_if.sink    item,
    hdt_result_if.source result,
    hdt_cfg_if.sink     cfg
);
    import hdt_pkg::*;

    localparam int SCAN_N = (BEAM_SEGMENTS > TILE_COUNT) ? BEAM_SEGMENTS : TILE_COUNT;
    localparam int SCAN_W = $clog2(SCAN_N);

    cfg_t              cfg_q;
    item_t             item_d;
    cmd_t              cmd;
    status_t           status;
    res_t              res;
    logic [SCAN_W-1:0] scan_idx;

    assign item_d.action         = item.action;
    assign item_d.hit_position_x = item.hit_position_x;
    assign item_d.tile_number    = item.tile_number;
    assign item_d.hit_energy_kev = item.hit_energy_kev;
    assign item_d.origin_tag     = item.origin_tag;
    assign item_d.particle_code  = item.particle_code;
    assign item_d.target_touched = item.target_touched;

    hdt_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    hdt_ctrl #(
        .SCAN_N (SCAN_N),
        .SCAN_W (SCAN_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd),
        .scan_idx     (scan_idx)
    );

    hdt_datapath #(
        .BEAM_SEGMENTS (BEAM_SEGMENTS),
        .TILE_COUNT    (TILE_COUNT),
        .SCAN_W        (SCAN_W)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item_d),
        .cfg_q    (cfg_q),
        .cmd      (cmd),
        .scan_idx (scan_idx),
        .status   (status),
        .res      (res)
    );

    assign result.event_used        = res.event_used;
    assign result.beam_present      = res.beam_present;
    assign result.trigger_fired     = res.trigger_fired;
    assign result.veto_tight        = res.veto_tight;
    assign result.veto_fit          = res.veto_fit;
    assign result.veto_wide         = res.veto_wide;
    assign result.veto_ultra        = res.veto_ultra;
    assign result.tile_multiplicity = res.tile_multiplicity;

endmodule

>>> rtl/hdt_cfg_regs.sv
module hdt_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    hdt_cfg_if.sink       cfg,
    output hdt_pkg::cfg_t cfg_q
);
    import hdt_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_BEAM_LO:   cfg_next.beam_lo   = cfg.data[3:0];
                REG_BEAM_HI:   cfg_next.beam_hi   = cfg.data[3:0];
                REG_BEAM_THR:  cfg_next.beam_thr  = cfg.data[ENERGY_W-1:0];
                REG_TILE_THR:  cfg_next.tile_thr  = cfg.data[ENERGY_W-1:0];
                REG_ORIGIN_EN: cfg_next.origin_en = cfg.data[0];
                REG_TARGET_EN: cfg_next.target_en = cfg.data[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.beam_lo   <= 4'd4;
            cfg_reg.beam_hi   <= 4'd10;
            cfg_reg.beam_thr  <= 24'd100;
            cfg_reg.tile_thr  <= 24'd200;
            cfg_reg.origin_en <= 1'b1;
            cfg_reg.target_en <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/hdt_ctrl.sv
module hdt_ctrl #(
    parameter int SCAN_N = 34,
    parameter int SCAN_W = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    output logic             result_valid,
    input  logic             result_ready,
    input  hdt_pkg::status_t status,
    output hdt_pkg::cmd_t    cmd,
    output logic [SCAN_W-1:0] scan_idx
);
    import hdt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_LAST = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(SCAN_N - 1);

    logic [2:0]        state_reg, state_next;
    logic [SCAN_W-1:0] scan_idx_reg, scan_idx_next;
    logic              result_valid_reg, result_valid_next;

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign scan_idx     = scan_idx_reg;

    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    case (status.act)
                        ACT_BEAM, ACT_TILE: state_next = S_UPD;
                        ACT_END:
                        begin
                            state_next    = S_SCAN;
                            scan_idx_next = '0;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                if (scan_idx_reg == SCAN_LAST)
                    state_next = S_LAST;
                else
                    scan_idx_next = scan_idx_reg + 1'b1;
            end
            S_LAST:
            begin
                // last compare stage completes here
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (cmd.load_out)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            scan_idx_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            scan_idx_reg     <= scan_idx_next;
            result_valid_reg <= result_valid_next;
        end
    end

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> scan_idx_reg <= SCAN_LAST)
        else $error("scan index past last address");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result_valid_reg || result_ready))
        else $error("result loaded over an undelivered one");

    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && status.act == ACT_END) |=>
            (state_reg == S_SCAN && scan_idx_reg == '0))
        else $error("end of event did not start the scan at zero");

endmodule

>>> rtl/hdt_datapath.sv
module hdt_datapath #(
    parameter int BEAM_SEGMENTS = 15,
    parameter int TILE_COUNT    = 34,
    parameter int SCAN_W        = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hdt_pkg::item_t    item,
    input  hdt_pkg::cfg_t     cfg_q,
    input  hdt_pkg::cmd_t     cmd,
    input  logic [SCAN_W-1:0] scan_idx,
    output hdt_pkg::status_t  status,
    output hdt_pkg::res_t     res
);
    import hdt_pkg::*;

    localparam int SEG_W  = (BEAM_SEGMENTS > 1) ? $clog2(BEAM_SEGMENTS) : 1;
    localparam int TILE_W = $clog2(TILE_COUNT);
    localparam int OFFSET_Q4 = X_OFFSET_Q4 + BEAM_SEGMENTS * (SEG_PITCH_Q4 / 2);
    localparam int SPAN_Q4   = BEAM_SEGMENTS * SEG_PITCH_Q4;

    // ---------------- hit decode ----------------
    logic signed [18:0] pos_u;
    logic               beam_keep;
    logic [8:0]         pos_coarse;
    logic [20:0]        div_prod;
    logic [SEG_W-1:0]   seg_idx;
    logic               charged;
    logic               tile_keep;

    assign status.act = item.action;

    assign pos_u      = {{2{item.hit_position_x[16]}}, item.hit_position_x}
                        + 19'(OFFSET_Q4);
    assign beam_keep  = !pos_u[18] && (pos_u[17:0] < 18'(SPAN_Q4));
    assign pos_coarse = pos_u[PITCH_SHIFT+8:PITCH_SHIFT];
    assign div_prod   = 21'(pos_coarse) * 21'(DIV7_MUL);
    assign seg_idx    = div_prod[DIV7_SHIFT+SEG_W-1:DIV7_SHIFT];

    assign charged = (item.particle_code == 32'sd0)
                  || (item.particle_code == 32'sd211)  || (item.particle_code == -32'sd211)
                  || (item.particle_code == 32'sd321)  || (item.particle_code == -32'sd321)
                  || (item.particle_code == 32'sd2212) || (item.particle_code == -32'sd2212)
                  || (item.particle_code == 32'sd11)   || (item.particle_code == -32'sd11)
                  || (item.particle_code == 32'sd13)   || (item.particle_code == -32'sd13);

    assign tile_keep = ({1'b0, item.tile_number} < 7'(TILE_COUNT))
                    && (!cfg_q.origin_en || item.origin_tag == 32'd1)
                    && charged;

    // ---------------- captured hit ----------------
    logic                keep_reg;
    logic                is_beam_reg;
    logic [HIT_E_W-1:0]  energy_reg;
    logic [SEG_W-1:0]    seg_idx_reg;
    logic [TILE_W-1:0]   tile_idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            is_beam_reg  <= (item.action == ACT_BEAM);
            keep_reg     <= ((item.action == ACT_BEAM) && beam_keep)
                         || ((item.action == ACT_TILE) && tile_keep);
            energy_reg   <= item.hit_energy_kev;
            seg_idx_reg  <= seg_idx;
            tile_idx_reg <= item.tile_number[TILE_W-1:0];
        end
    end

    // ---------------- accumulator memories ----------------
    logic [ENERGY_W-1:0] seg_mem  [BEAM_SEGMENTS];
    logic [ENERGY_W-1:0] tile_mem [TILE_COUNT];
    logic [ENERGY_W-1:0] seg_rdata_reg, tile_rdata_reg;
    logic [SEG_W-1:0]    seg_raddr;
    logic [TILE_W-1:0]   tile_raddr;
    logic [BEAM_SEGMENTS-1:0] seg_hit_reg;
    logic [TILE_COUNT-1:0]    tile_hit_reg;

    logic                seg_we, tile_we;
    logic [ENERGY_W-1:0] acc_old;
    logic [ENERGY_W:0]   acc_sum;
    logic [ENERGY_W-1:0] acc_sat;

    assign seg_raddr  = cmd.scan_rd ? scan_idx[SEG_W-1:0] : seg_idx;
    assign tile_raddr = cmd.scan_rd ? scan_idx[TILE_W-1:0] : item.tile_number[TILE_W-1:0];

    assign seg_we  = cmd.update && keep_reg && is_beam_reg;
    assign tile_we = cmd.update && keep_reg && !is_beam_reg;

    // an entry without its hit flag reads as zero
    always_comb
    begin
        acc_old = '0;
        if (keep_reg)
        begin
            if (is_beam_reg)
                acc_old = seg_hit_reg[seg_idx_reg] ? seg_rdata_reg : '0;
            else
                acc_old = tile_hit_reg[tile_idx_reg] ? tile_rdata_reg : '0;
        end
    end

    assign acc_sum = {1'b0, acc_old} + {{(ENERGY_W+1-HIT_E_W){1'b0}}, energy_reg};
    assign acc_sat = acc_sum[ENERGY_W] ? {ENERGY_W{1'b1}} : acc_sum[ENERGY_W-1:0];

    always_ff @(posedge clk)
    begin
        if (seg_we)
            seg_mem[seg_idx_reg] <= acc_sat;
        seg_rdata_reg <= seg_mem[seg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tile_we)
            tile_mem[tile_idx_reg] <= acc_sat;
        tile_rdata_reg <= tile_mem[tile_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_hit_reg  <= '0;
            tile_hit_reg <= '0;
        end
        else if (cmd.load_out)
        begin
            seg_hit_reg  <= '0;
            tile_hit_reg <= '0;
        end
        else
        begin
            if (seg_we)
                seg_hit_reg[seg_idx_reg] <= 1'b1;
            if (tile_we)
                tile_hit_reg[tile_idx_reg] <= 1'b1;
        end
    end

    // ---------------- end-of-event scan ----------------
    logic              pipe_vld_reg;
    logic [SCAN_W-1:0] pipe_idx_reg;
    logic              seg_in, tile_in, seg_ok, tile_ok, near_in;
    logic [2:0]        near_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pipe_vld_reg <= 1'b0;
        else
            pipe_vld_reg <= cmd.scan_rd;
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= scan_idx;
    end

    assign seg_in  = {1'b0, pipe_idx_reg} < (SCAN_W+1)'(BEAM_SEGMENTS);
    assign tile_in = {1'b0, pipe_idx_reg} < (SCAN_W+1)'(TILE_COUNT);

    assign seg_ok = seg_in
                 && seg_hit_reg[pipe_idx_reg[SEG_W-1:0]]
                 && (seg_rdata_reg >= cfg_q.beam_thr)
                 && (pipe_idx_reg >= SCAN_W'(cfg_q.beam_lo))
                 && (pipe_idx_reg <= SCAN_W'(cfg_q.beam_hi));

    assign tile_ok = tile_in
                  && tile_hit_reg[pipe_idx_reg[TILE_W-1:0]]
                  && (tile_rdata_reg >= cfg_q.tile_thr);

    assign near_in  = (pipe_idx_reg >= SCAN_W'(VETO_BASE_TILE))
                   && (pipe_idx_reg <= SCAN_W'(VETO_BASE_TILE + 5));
    assign near_sel = 3'(pipe_idx_reg - SCAN_W'(VETO_BASE_TILE));

    logic              used_reg;
    logic              beam_reg;
    logic [MULT_W-1:0] mult_reg;
    logic [5:0]        near_reg;   // bit k: tile 16+k valid

    always_ff @(posedge clk)
    begin
        if (cmd.capture && item.action == ACT_END)
        begin
            used_reg <= !(cfg_q.target_en && !item.target_touched);
            beam_reg <= 1'b0;
            mult_reg <= '0;
            near_reg <= '0;
        end
        else if (pipe_vld_reg)
        begin
            if (seg_ok)
                beam_reg <= 1'b1;
            if (tile_ok && mult_reg != MULT_MAX)
                mult_reg <= mult_reg + 1'b1;
            if (near_in)
                near_reg[near_sel] <= tile_ok;
        end
    end

    // ---------------- result ----------------
    logic beam_v, trig_v, tight_v, fit_v, wide_v;
    res_t res_reg;

    assign beam_v  = used_reg && beam_reg;
    assign trig_v  = beam_v && (mult_reg >= MULT_W'(2));
    assign tight_v = trig_v && ((near_reg[1] && near_reg[2]) || (near_reg[2] && near_reg[3]));
    assign fit_v   = tight_v || (trig_v && near_reg[3] && near_reg[4]);
    assign wide_v  = fit_v || (trig_v && near_reg[0] && near_reg[1]);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            res_reg.event_used        <= used_reg;
            res_reg.beam_present      <= beam_v;
            res_reg.trigger_fired     <= trig_v;
            res_reg.veto_tight        <= tight_v;
            res_reg.veto_fit          <= fit_v;
            res_reg.veto_wide         <= wide_v;
            res_reg.veto_ultra        <= wide_v || (trig_v && near_reg[4] && near_reg[5]);
            res_reg.tile_multiplicity <= used_reg ? mult_reg : '0;
        end
    end

    assign res = res_reg;

endmodule

>>> sim/hodoscope_trigger_veto_core_test.sv
`timescale 1ns / 1ps

module hodoscope_trigger_veto_core_test;

    import hdt_pkg::*;

    localparam int BEAM_SEGMENTS = 15;
    localparam int TILE_COUNT    = 34;

    localparam logic [1:0]           ACT_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 5000;
    localparam int RANDOM_ITEMS  = 18;

    logic clk = 1'b0;
    logic rst_n;

    hdt_item_if   hit_bus ();
    hdt_result_if trig_bus ();
    hdt_cfg_if    cfg_bus ();

    hodoscope_trigger_veto_core #(
        .BEAM_SEGMENTS (BEAM_SEGMENTS),
        .TILE_COUNT    (TILE_COUNT)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (hit_bus),
        .result (trig_bus),
        .cfg    (cfg_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the block: registers and per-event accumulators
    cfg_t                regs_shadow;
    logic [ENERGY_W-1:0] seg_sum  [BEAM_SEGMENTS];
    logic                seg_seen [BEAM_SEGMENTS];
    logic [ENERGY_W-1:0] tile_sum  [TILE_COUNT];
    logic                tile_seen [TILE_COUNT];

    item_t pending_requests [$];
    res_t  expected_triggers [$];
    item_t offered;
    res_t  want_trig;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int failures = 0;
    int requests_queued = 0;
    int requests_accepted = 0;
    int results_checked = 0;
    int settings_used = 0;
    int quiet_cycles = 0;
    int hold_left = 0;
    bit hold_arm = 1'b0;
    bit hold_done = 1'b0;

    function automatic void clear_sums();
        for (int s = 0; s < BEAM_SEGMENTS; s++)
        begin
            seg_sum[s] = '0;
            seg_seen[s] = 1'b0;
        end
        for (int t = 0; t < TILE_COUNT; t++)
        begin
            tile_sum[t] = '0;
            tile_seen[t] = 1'b0;
        end
    endfunction

    function automatic logic [ENERGY_W-1:0] sat_add(logic [ENERGY_W-1:0] sum,
                                                   logic [HIT_E_W-1:0] e);
        logic [ENERGY_W:0] s;
        s = {1'b0, sum} + {{(ENERGY_W+1-HIT_E_W){1'b0}}, e};
        return s[ENERGY_W] ? {ENERGY_W{1'b1}} : s[ENERGY_W-1:0];
    endfunction

    function automatic bit is_charged(logic signed [31:0] code);
        longint v;
        longint m;
        v = longint'(code);
        m = (v < 0) ? -v : v;
        return v == 0 || m == 211 || m == 321 || m == 2212 || m == 11 || m == 13;
    endfunction

    function automatic bit tile_valid(int t);
        return tile_seen[t] && tile_sum[t] >= regs_shadow.tile_thr;
    endfunction

    function automatic bit pair_valid(int a, int b);
        return tile_valid(a) && tile_valid(b);
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        case (idx)
            REG_BEAM_LO:   regs_shadow.beam_lo = v[3:0];
            REG_BEAM_HI:   regs_shadow.beam_hi = v[3:0];
            REG_BEAM_THR:  regs_shadow.beam_thr = v[ENERGY_W-1:0];
            REG_TILE_THR:  regs_shadow.tile_thr = v[ENERGY_W-1:0];
            REG_ORIGIN_EN: regs_shadow.origin_en = v[0];
            REG_TARGET_EN: regs_shadow.target_en = v[0];
            default: ;
        endcase
    endfunction

    // accumulate one hit, or close the event and queue its trigger word
    function automatic void predict_trigger(item_t req);
        int   u;
        int   t;
        int   mult;
        bit   used;
        bit   beam;
        res_t r;
        r = '0;
        case (req.action)
            ACT_BEAM:
            begin
                u = int'($signed(req.hit_position_x)) + X_OFFSET_Q4
                    + BEAM_SEGMENTS * SEG_PITCH_Q4 / 2;
                if (u >= 0 && u < BEAM_SEGMENTS * SEG_PITCH_Q4)
                begin
                    seg_sum[u / SEG_PITCH_Q4] = sat_add(seg_sum[u / SEG_PITCH_Q4],
                                                        req.hit_energy_kev);
                    seg_seen[u / SEG_PITCH_Q4] = 1'b1;
                end
            end
            ACT_TILE:
            begin
                t = int'(req.tile_number);
                if (t < TILE_COUNT && !(regs_shadow.origin_en && req.origin_tag != 32'd1)
                    && is_charged(req.particle_code))
                begin
                    tile_sum[t] = sat_add(tile_sum[t], req.hit_energy_kev);
                    tile_seen[t] = 1'b1;
                end
            end
            ACT_END:
            begin
                used = !(regs_shadow.target_en && !req.target_touched);
                beam = 1'b0;
                mult = 0;
                if (used)
                begin
                    for (int s = 0; s < BEAM_SEGMENTS; s++)
                        if (seg_seen[s] && seg_sum[s] >= regs_shadow.beam_thr
                            && s >= regs_shadow.beam_lo && s <= regs_shadow.beam_hi)
                            beam = 1'b1;
                    for (int k = 0; k < TILE_COUNT; k++)
                        if (tile_valid(k))
                            mult++;
                    r.beam_present = beam;
                    r.trigger_fired = beam && mult >= 2;
                    if (r.trigger_fired)
                    begin
                        // nested window, growing outwards from tile 18
                        r.veto_tight = pair_valid(17, 18) || pair_valid(18, 19);
                        r.veto_fit   = r.veto_tight || pair_valid(19, 20);
                        r.veto_wide  = r.veto_fit || pair_valid(16, 17);
                        r.veto_ultra = r.veto_wide || pair_valid(20, 21);
                    end
                    r.tile_multiplicity = (mult > int'(MULT_MAX)) ? MULT_MAX : mult[MULT_W-1:0];
                end
                r.event_used = used;
                expected_triggers.push_back(r);
                clear_sums();
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [MULT_W-1:0] want,
                                        logic [MULT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    function automatic void check_flag(string name, logic want, logic got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
            hit_bus.valid <= 1'b0;
        else
        begin
            if (hit_bus.valid && hit_bus.ready)
            begin
                predict_trigger(offered);
                requests_accepted++;
            end
            if (!hit_bus.valid || hit_bus.ready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = pending_requests.pop_front();
                    hit_bus.valid          <= 1'b1;
                    hit_bus.action         <= offered.action;
                    hit_bus.hit_position_x <= offered.hit_position_x;
                    hit_bus.tile_number    <= offered.tile_number;
                    hit_bus.hit_energy_kev <= offered.hit_energy_kev;
                    hit_bus.origin_tag     <= offered.origin_tag;
                    hit_bus.particle_code  <= offered.particle_code;
                    hit_bus.target_touched <= offered.target_touched;
                end
                else
                    hit_bus.valid <= 1'b0;
            end
        end
    end

    // result monitor, with its own long hold-off when armed
    always @(posedge clk)
    begin
        if (!rst_n)
            trig_bus.ready <= 1'b0;
        else
        begin
            if (trig_bus.valid && trig_bus.ready)
            begin
                if (expected_triggers.size() == 0)
                begin
                    $error("trigger result arrived with nothing outstanding");
                    failures++;
                end
                else
                begin
                    want_trig = expected_triggers.pop_front();
                    check_flag("event_used", want_trig.event_used, trig_bus.event_used);
                    check_flag("beam_present", want_trig.beam_present, trig_bus.beam_present);
                    check_flag("trigger_fired", want_trig.trigger_fired,
                               trig_bus.trigger_fired);
                    check_flag("veto_tight", want_trig.veto_tight, trig_bus.veto_tight);
                    check_flag("veto_fit", want_trig.veto_fit, trig_bus.veto_fit);
                    check_flag("veto_wide", want_trig.veto_wide, trig_bus.veto_wide);
                    check_flag("veto_ultra", want_trig.veto_ultra, trig_bus.veto_ultra);
                    check_field("tile_multiplicity", want_trig.tile_multiplicity,
                                trig_bus.tile_multiplicity);
                    results_checked++;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                trig_bus.ready <= 1'b0;
            end
            else if (hold_arm && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                trig_bus.ready <= 1'b0;
            end
            else
                trig_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((hit_bus.valid && hit_bus.ready) || (trig_bus.valid && trig_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // stimulus helpers
    function automatic item_t noise_item();
        item_t it;
        it.action         = 2'($urandom_range(0, 3));
        it.hit_position_x = 17'($urandom);
        it.tile_number    = 6'($urandom);
        it.hit_energy_kev = 16'($urandom);
        it.origin_tag     = $urandom;
        it.particle_code  = $urandom;
        it.target_touched = 1'($urandom);
        return it;
    endfunction

    function automatic logic signed [31:0] charged_code();
        logic signed [31:0] c;
        case ($urandom_range(0, 5))
            0: c = 0;
            1: c = 211;
            2: c = 321;
            3: c = 2212;
            4: c = 11;
            default: c = 13;
        endcase
        return $urandom_range(0, 1) ? -c : c;
    endfunction

    function automatic logic [HIT_E_W-1:0] pick_energy();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4: return HIT_E_W'($urandom);
            default: return HIT_E_W'($urandom_range(0, 600));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] with_junk(logic [CFG_DATA_W-1:0] v, int w);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        return (junk << w) | v;
    endfunction

    task automatic add_request(item_t it);
        pending_requests.push_back(it);
        if (it.action != ACT_UNUSED)
            requests_queued++;
    endtask

    task automatic beam_req(logic signed [16:0] x, logic [HIT_E_W-1:0] e);
        item_t it;
        it = noise_item();
        it.action = ACT_BEAM;
        it.hit_position_x = x;
        it.hit_energy_kev = e;
        add_request(it);
    endtask

    task automatic tile_req(logic [5:0] t, logic [HIT_E_W-1:0] e, logic [31:0] tag,
                            logic signed [31:0] code);
        item_t it;
        it = noise_item();
        it.action = ACT_TILE;
        it.tile_number = t;
        it.hit_energy_kev = e;
        it.origin_tag = tag;
        it.particle_code = code;
        add_request(it);
    endtask

    task automatic end_req(logic touched);
        item_t it;
        it = noise_item();
        it.action = ACT_END;
        it.target_touched = touched;
        add_request(it);
    endtask

    task automatic add_random_event();
        int    n;
        int    kind;
        item_t it;
        n = $urandom_range(0, 9);
        repeat (n)
        begin
            kind = $urandom_range(0, 99);
            it = noise_item();
            if (kind < 35)
            begin
                it.action = ACT_BEAM;
                if ($urandom_range(0, 9) != 0)
                    it.hit_position_x = 17'($urandom_range(0, 3359) - 1840);
                it.hit_energy_kev = pick_energy();
            end
            else if (kind < 88)
            begin
                it.action = ACT_TILE;
                // weight towards the veto window
                if ($urandom_range(0, 3) != 0)
                    it.tile_number = 6'($urandom_range(14, 23));
                if ($urandom_range(0, 9) != 0)
                    it.origin_tag = 32'd1;
                if ($urandom_range(0, 7) != 0)
                    it.particle_code = charged_code();
                it.hit_energy_kev = pick_energy();
            end
            add_request(it);
        end
        end_req($urandom_range(0, 3) != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= v;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        apply_reg(idx, v);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic write_settings(logic [3:0] lo, logic [3:0] hi, logic [23:0] bthr,
                                  logic [23:0] tthr, logic origin, logic target);
        write_reg(REG_BEAM_LO, with_junk(CFG_DATA_W'(lo), 4));
        write_reg(REG_BEAM_HI, with_junk(CFG_DATA_W'(hi), 4));
        write_reg(REG_BEAM_THR, bthr);
        write_reg(REG_TILE_THR, tthr);
        write_reg(REG_ORIGIN_EN, with_junk(CFG_DATA_W'(origin), 1));
        write_reg(REG_TARGET_EN, with_junk(CFG_DATA_W'(target), 1));
        settings_used++;
    endtask

    task automatic write_random_settings();
        write_settings(4'($urandom_range(0, 14)), 4'($urandom_range(0, 14)),
                       24'($urandom_range(0, 3000)), 24'($urandom_range(0, 3000)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || hit_bus.valid || expected_triggers.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(int send_pct, int recv_pct, int n_random);
        int goal;
        @(negedge clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        goal = requests_queued + n_random;
        while (requests_queued < goal)
            add_random_event();
        drain();
    endtask

    initial
    begin
        item_t it;
        rst_n = 1'b0;
        hit_bus.valid = 1'b0;
        hit_bus.action = ACT_BEAM;
        hit_bus.hit_position_x = '0;
        hit_bus.tile_number = '0;
        hit_bus.hit_energy_kev = '0;
        hit_bus.origin_tag = '0;
        hit_bus.particle_code = '0;
        hit_bus.target_touched = 1'b0;
        trig_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_BEAM_LO;
        cfg_bus.data = '0;
        regs_shadow = '{beam_lo: 4'd4, beam_hi: 4'd10, beam_thr: 24'd100, tile_thr: 24'd200,
                        origin_en: 1'b1, target_en: 1'b0};
        clear_sums();
        settings_used = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed events under reset settings
        @(negedge clk);
        send_idle_pct = 32;
        recv_idle_pct = 85;
        beam_req(-65536, 16'hFFFF);
        beam_req(65535, 16'hFFFF);
        beam_req(-1841, 500);            // just below segment 0
        beam_req(1520, 500);             // just past the last segment
        beam_req(-1840, 500);            // segment 0, outside the beam range
        beam_req(1519, 500);             // segment 14, outside the beam range
        beam_req(-944, 100);             // segment 4, exactly at threshold
        tile_req(17, 200, 1, 0);
        tile_req(18, 16'hFFFF, 1, -2212);
        tile_req(33, 300, 1, 211);
        tile_req(34, 500, 1, 211);       // tile beyond the barrel
        tile_req(19, 500, 2, 211);       // wrong origin
        tile_req(20, 500, 1, 22);        // neutral
        it = noise_item();
        it.action = ACT_UNUSED;
        add_request(it);
        end_req(1'b0);
        beam_req(624, 1000);             // segment 11, above the range
        tile_req(16, 300, 1, 211);
        tile_req(21, 16'hFFFF, 1, -13);
        tile_req(22, 500, 1, 32'sh80000000);
        tile_req(23, 500, 1, 32'sh7FFFFFFF);
        end_req(1'b1);
        beam_req(623, 99);               // segment 10, one short of threshold
        tile_req(20, 199, 1, 321);
        end_req(1'b1);
        beam_req(-1, 200);
        tile_req(20, 300, 1, 11);
        tile_req(21, 300, 1, 13);
        end_req(1'b0);                   // only the outermost pair fires
        run_phase(32, 85, RANDOM_ITEMS);

        write_settings(4'd0, 4'd14, 24'd0, 24'd0, 1'b0, 1'b1);
        write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
        run_phase(32, 85, RANDOM_ITEMS);

        // empty beam range
        write_settings(4'd9, 4'd3, 24'($urandom_range(0, 3000)), 24'($urandom_range(0, 3000)),
                       1'b1, 1'b0);
        run_phase(85, 32, RANDOM_ITEMS);

        write_random_settings();
        run_phase(85, 32, RANDOM_ITEMS);

        // full-scale thresholds: only saturated sums reach them
        write_settings(4'd14, 4'd14, 24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0);
        @(negedge clk);
        repeat (257) beam_req(1519, 16'hFFFF);
        repeat (257) tile_req(18, 16'hFFFF, $urandom, charged_code());
        end_req(1'b1);
        run_phase(0, 0, 8);

        write_random_settings();
        @(negedge clk);
        hold_arm = 1'b1;
        run_phase(0, 0, RANDOM_ITEMS);

        if (expected_triggers.size() != 0)
        begin
            $error("%0d trigger results never arrived", expected_triggers.size());
            failures++;
        end
        $display("Checked %0d trigger results from %0d requests over %0d register settings,",
                 results_checked, requests_accepted, settings_used);
        $display("including saturated sums, an empty beam range and a %0d-cycle output stall",
                 HOLD_CYCLES);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
rtl/hdt_pkg.sv
rtl/hdt_item_if.sv
rtl/hdt_result_if.sv
rtl/hdt_cfg_if.sv
rtl/hdt_cfg_regs.sv
rtl/hdt_ctrl.sv
rtl/hdt_datapath.sv
rtl/hodoscope_trigger_veto_core.sv
sim/hodoscope_trigger_veto_core_test.sv
